@@ sv/dq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_DEPTH    = 64;
    localparam int DQ_DATA_W   = 32;
    localparam int DQ_OPCODE_W = 3;
    localparam int DQ_STATUS_W = 2;

    typedef enum logic [DQ_OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } t_dq_op;

    typedef enum logic [DQ_STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_dq_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } t_dq_state;

    // controller to datapath
    typedef struct packed {
        logic take;      // input transaction accepted, execute its opcode
        logic rd_issue;  // read the next dump entry
        logic rd_load;   // move the read data into the output register
    } t_dq_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic dump_go;   // current input is a dump of a non-empty queue
        logic rd_done;   // no dump entries left to read
    } t_dq_sts;

endpackage

@@ sv/dq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/dq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// controller: input handshake and the dump read sequence
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dq_pkg::t_dq_sts i_sts,
    output dq_pkg::t_dq_cmd o_cmd
);

    import dq_pkg::*;

    t_dq_state r_state;
    t_dq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = i_sts.out_free;
                o_cmd.take = i_valid && i_sts.out_free;
                if (o_cmd.take && i_sts.dump_go) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_WAIT;
            end
            ST_WAIT: begin
                // read data holds until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.rd_load = 1'b1;
                    n_state       = i_sts.rd_done ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/dq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_dp
// datapath: ring pointers, occupancy, entry ram and output register
// ----------------------------------------------------------------------------
module dq_dp #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dq_pkg::t_dq_cmd                 i_cmd,
    output dq_pkg::t_dq_sts                 o_sts,
    input  logic [dq_pkg::DQ_OPCODE_W-1:0]  i_opcode,
    input  logic [dq_pkg::DQ_DATA_W-1:0]    i_value,
    input  logic                            i_m_ready,
    output logic                            o_m_valid,
    output logic [dq_pkg::DQ_DATA_W-1:0]    o_m_entry,
    output logic [dq_pkg::DQ_STATUS_W-1:0]  o_m_status,
    output logic                            o_m_last
);

    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_remain, n_remain;
    logic             r_out_valid, n_out_valid;
    logic [DQ_DATA_W-1:0]   r_out_entry, n_out_entry;
    logic [DQ_STATUS_W-1:0] r_out_status, n_out_status;
    logic                   r_out_last, n_out_last;

    logic             full, empty;
    logic [PTR_W-1:0] front_dec;
    logic [SUM_W-1:0] back_sum;
    logic [PTR_W-1:0] back_slot;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [DQ_DATA_W-1:0] ram_rdata;
    t_dq_op           op;

    assign op    = t_dq_op'(i_opcode);
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - PTR_W'(1);
    // free slot past the back: front + count, wrapped once
    assign back_sum  = SUM_W'(r_front) + SUM_W'(r_count);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                   : back_sum[PTR_W-1:0];

    assign o_sts.out_free = !r_out_valid || i_m_ready;
    assign o_sts.dump_go  = (op == OP_DUMP) && !empty;
    assign o_sts.rd_done  = (r_remain == '0);

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_entry  = r_out_entry;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = back_slot;

        if (i_cmd.take) begin
            n_out_entry = '0;
            n_out_last  = 1'b1;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out_status = STAT_OVERFLOW;
                    end else begin
                        n_out_status = STAT_OK;
                        ram_we       = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        if (op == OP_PUSH_FRONT) begin
                            ram_waddr = front_dec;
                            n_front   = front_dec;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    n_out_valid = 1'b1;
                    if (empty) begin
                        n_out_status = STAT_UNDERFLOW;
                    end else begin
                        n_out_status = STAT_OK;
                        n_count      = r_count - CNT_W'(1);
                        if (op == OP_POP_FRONT) begin
                            n_front = (r_front == PTR_W'(DEPTH - 1)) ? '0
                                                                     : r_front + PTR_W'(1);
                        end
                    end
                end
                OP_DUMP: begin
                    if (empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STAT_UNDERFLOW;
                    end else begin
                        n_rd_ptr = r_front;
                        n_remain = r_count;
                    end
                end
                default: begin
                    // unused opcodes produce nothing
                end
            endcase
        end

        if (i_cmd.rd_issue) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            n_remain = r_remain - CNT_W'(1);
        end

        if (i_cmd.rd_load) begin
            n_out_valid  = 1'b1;
            n_out_entry  = ram_rdata;
            n_out_status = STAT_OK;
            n_out_last   = (r_remain == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr     <= n_rd_ptr;
        r_out_entry  <= n_out_entry;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    dq_ram #(
        .WIDTH (DQ_DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_m_valid  = r_out_valid;
    assign o_m_entry  = r_out_entry;
    assign o_m_status = r_out_status;
    assign o_m_last   = r_out_last;

endmodule

@@ sv/double_ended_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values kept in a ring with front pointer
// and occupancy count; push/pop at either end, and a front-to-back dump
// ----------------------------------------------------------------------------
//  channel   | dir | tdata           | tuser           | tlast
//  s_axis    | in  | value [31:0]    | opcode [2:0]    | -
//  m_axis    | out | entry [31:0]    | status [1:0]    | last of item
//
//  push and pop: one transaction per cycle while the output register is free,
//  result in the output register on the next cycle
//  dump of n entries: per entry a ram read issue, then a load that waits for
//  a free output register; input held off until the last entry is loaded
//  reset is synchronous, active low, clears front pointer, count, dump remainder and output valid
//  a result held in the output register stalls input and dump reads until
//  m_axis_tready takes it
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [dq_pkg::DQ_DATA_W-1:0]    i_s_axis_tdata,   // value
    input  logic [dq_pkg::DQ_OPCODE_W-1:0]  i_s_axis_tuser,   // opcode
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dq_pkg::DQ_DATA_W-1:0]    o_m_axis_tdata,   // entry
    output logic [dq_pkg::DQ_STATUS_W-1:0]  o_m_axis_tuser,   // status
    output logic                            o_m_axis_tlast
);

    import dq_pkg::*;

    t_dq_cmd cmd;
    t_dq_sts sts;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_opcode   (i_s_axis_tuser),
        .i_value    (i_s_axis_tdata),
        .i_m_ready  (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_entry  (o_m_axis_tdata),
        .o_m_status (o_m_axis_tuser),
        .o_m_last   (o_m_axis_tlast)
    );

endmodule
